>>> rtl/ygbd_pkg.sv
// Shared constants, register indexes and helper functions of the YOLO grid box decoder.
`default_nettype none
package ygbd_pkg;

    localparam int DEF_MAX_CLASSES      = 128;
    localparam int DEF_ANCHORS_PER_CELL = 3;
    localparam int DEF_MAX_GRID_SIDE    = 512;
    localparam int DEF_SIG_DEPTH        = 1024;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_STRIDE_SHIFT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_WIDTH     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_HEIGHT    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE       = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ZERO     = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_ONE      = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_TWO      = 8'd7;

    localparam logic [63:0] EXP_STEP_Q32 = 64'd4278222805;

    typedef struct packed {
        logic [2:0]  stride_shift;
        logic [12:0] model_width;
        logic [12:0] model_height;
        logic [15:0] min_score;
        logic [7:0]  class_count;
        logic [31:0] anchor_zero;
        logic [31:0] anchor_one;
        logic [31:0] anchor_two;
    } cfg_t;

    // elaboration-time restoring divide
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], n[k]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_q32(input logic [15:0] mag);
        logic [63:0] r;
        logic [63:0] b;
        r = 64'd1 << 32;
        b = EXP_STEP_Q32;
        for (int k = 0; k < 16; k++) begin
            if (mag[k]) r = (r * b) >> 32;
            b = (b * b) >> 32;
        end
        return r;
    endfunction

    function automatic logic [15:0] sig_entry(input int i, input int depth);
        logic [63:0] cu;
        logic [63:0] mag;
        logic        neg;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] r;
        cu  = udiv(64'((2 * i + 1)) * 64'd65536, 64'(2 * depth));
        neg = cu < 64'd32768;
        mag = neg ? (64'd32768 - cu) : (cu - 64'd32768);
        e   = exp_neg_q32(mag[15:0]);
        den = (64'd1 << 32) + e;
        if (!neg) begin
            r = udiv((64'd1 << 48) + (den >> 1), den);
            if (r > 64'd65535) r = 64'd65535;
        end else begin
            r = udiv((e << 16) + (den >> 1), den);
        end
        return r[15:0];
    endfunction

    function automatic logic [15:0] to_q4(input logic signed [63:0] v);
        logic [63:0] q;
        if (v <= 64'sd0) return 16'd0;
        q = (64'(v) + (64'd1 << 27)) >> 28;
        return (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/yolo_grid_box_decoder.sv
// Top level of the YOLO grid box decoder: configuration registers, front, queue and back.
//
// Usage:
//   s_ channel: one signed Q8.8 feature value per transfer, ordered anchor, row,
//   column, element (four box logits, objectness, class logits). s_map_start
//   marks element 0 of a new map and restarts the position counters.
//   m_ channel: one decoded box per cell whose objectness and score pass
//   the minimum score; cells that fail produce no transfer.
//   cfg_wr_en/cfg_index/cfg_wr_data write the configuration registers; write
//   only while the block is idle.
// Throughput: the front takes one value per cycle while the queue is not full. The back
// works on one cell at a time, longer for a passing cell than a failing one (six sigmoid
// table reads through one registered port, then multiply, scale, edge, output and handoff
// steps), so shorter cells throttle the input; a two-entry queue lets the front run ahead.
// Reset: counters and argmax clear, registers take their defaults, m_valid drops.
// A stalled receiver holds the result; the back stops and the queue fills,
// after which s_ready drops.
`default_nettype none
module yolo_grid_box_decoder
    import ygbd_pkg::*;
#(
    parameter int MAX_CLASSES         = DEF_MAX_CLASSES,
    parameter int ANCHORS_PER_CELL    = DEF_ANCHORS_PER_CELL,
    parameter int MAX_GRID_SIDE       = DEF_MAX_GRID_SIDE,
    parameter int SIGMOID_TABLE_DEPTH = DEF_SIG_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [15:0]    s_logit,
    input  wire logic                  s_map_start,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [15:0]                m_box_left,
    output logic [15:0]                m_box_top,
    output logic [15:0]                m_box_right,
    output logic [15:0]                m_box_bottom,
    output logic [6:0]                 m_top_class,
    output logic [15:0]                m_score
);
    localparam int GW    = $clog2(MAX_GRID_SIDE + 1);
    localparam int AW    = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1;
    localparam int REC_W = 4 * 16 + 16 + 16 + 7 + 2 * GW + AW;

    cfg_t             cfg_reg;
    logic             push, pop, full, empty;
    logic [REC_W-1:0] wr_rec, rd_rec;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stride_shift    <= 3'd3;
            cfg_reg.model_width     <= 13'd640;
            cfg_reg.model_height    <= 13'd640;
            cfg_reg.min_score       <= 16'd45875;
            cfg_reg.class_count     <= 8'd80;
            cfg_reg.anchor_zero     <= 32'd655373;
            cfg_reg.anchor_one      <= 32'd1048606;
            cfg_reg.anchor_two      <= 32'd2162711;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_STRIDE_SHIFT:    cfg_reg.stride_shift    <= cfg_wr_data[2:0];
                REG_MODEL_WIDTH:     cfg_reg.model_width     <= cfg_wr_data[12:0];
                REG_MODEL_HEIGHT:    cfg_reg.model_height    <= cfg_wr_data[12:0];
                REG_MIN_SCORE:       cfg_reg.min_score       <= cfg_wr_data[15:0];
                REG_CLASS_COUNT:     cfg_reg.class_count     <= cfg_wr_data[7:0];
                REG_ANCHOR_ZERO:     cfg_reg.anchor_zero     <= cfg_wr_data;
                REG_ANCHOR_ONE:      cfg_reg.anchor_one      <= cfg_wr_data;
                REG_ANCHOR_TWO:      cfg_reg.anchor_two      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !full;

    ygbd_front #(
        .MAX_CLASSES(MAX_CLASSES), .ANCHORS_PER_CELL(ANCHORS_PER_CELL),
        .MAX_GRID_SIDE(MAX_GRID_SIDE), .GW(GW), .AW(AW), .REC_W(REC_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_logit(s_logit),
        .s_map_start(s_map_start), .push(push), .rec(wr_rec)
    );

    ygbd_fifo #(.WIDTH(REC_W)) u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .wr_data(wr_rec),
        .pop(pop), .rd_data(rd_rec), .full(full), .empty(empty)
    );

    ygbd_back #(
        .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH), .GW(GW), .AW(AW), .REC_W(REC_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .rec(rd_rec), .empty(empty),
        .pop(pop), .m_valid(m_valid), .m_ready(m_ready),
        .m_box_left(m_box_left), .m_box_top(m_box_top), .m_box_right(m_box_right),
        .m_box_bottom(m_box_bottom), .m_top_class(m_top_class), .m_score(m_score)
    );

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full)) else $error("queue overflow");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty)) else $error("queue underflow");
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("result valid after reset");
    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !pop) else $error("pop while result pending");
endmodule
`default_nettype wire

>>> rtl/ygbd_fifo.sv
// Two-entry queue between the cell classifier and the box decoder.
`default_nettype none
module ygbd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);
    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/ygbd_front.sv
// Front end: position counters, box logit capture and running class argmax.
`default_nettype none
module ygbd_front
    import ygbd_pkg::*;
#(
    parameter int MAX_CLASSES      = DEF_MAX_CLASSES,
    parameter int ANCHORS_PER_CELL = DEF_ANCHORS_PER_CELL,
    parameter int MAX_GRID_SIDE    = DEF_MAX_GRID_SIDE,
    parameter int GW               = $clog2(MAX_GRID_SIDE + 1),
    parameter int AW               = (ANCHORS_PER_CELL > 1) ? $clog2(ANCHORS_PER_CELL) : 1,
    parameter int REC_W            = 4 * 16 + 16 + 16 + 7 + 2 * GW + AW
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cfg_t              cfg,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic signed [15:0] s_logit,
    input  wire logic              s_map_start,
    output logic                   push,
    output logic       [REC_W-1:0] rec
);
    logic [7:0]        ec_reg, ec_cur;
    logic [GW-1:0]     col_reg, col_cur, row_reg, row_cur;
    logic [AW-1:0]     anc_reg, anc_cur;
    logic [15:0]       box_reg [4];
    logic [15:0]       obj_reg;
    logic signed [15:0] best_reg, best_next;
    logic [6:0]        bidx_reg, bidx_next;
    logic [7:0]        cc_eff;
    logic [8:0]        last;
    logic              end_cell, acc;
    logic [13:0]       wside, hside;

    function automatic logic [13:0] side(input logic [12:0] px, input logic [2:0] sh);
        logic [12:0] n;
        n = px >> sh;
        if (n == 13'd0) return 14'd1;
        if ({1'b0, n} > 14'(MAX_GRID_SIDE)) return 14'(MAX_GRID_SIDE);
        return {1'b0, n};
    endfunction

    assign acc     = s_valid && s_ready;
    assign ec_cur  = s_map_start ? 8'd0 : ec_reg;
    assign col_cur = s_map_start ? '0 : col_reg;
    assign row_cur = s_map_start ? '0 : row_reg;
    assign anc_cur = s_map_start ? '0 : anc_reg;
    assign cc_eff  = (cfg.class_count == 8'd0) ? 8'd1 :
                     (cfg.class_count > 8'(MAX_CLASSES)) ? 8'(MAX_CLASSES) : cfg.class_count;
    assign last     = 9'd4 + {1'b0, cc_eff};
    assign end_cell = {1'b0, ec_cur} >= last;
    assign wside    = side(cfg.model_width, cfg.stride_shift);
    assign hside    = side(cfg.model_height, cfg.stride_shift);

    always_comb begin
        best_next = best_reg;
        bidx_next = bidx_reg;
        if (ec_cur == 8'd4) begin
            best_next = -16'sd32768;
            bidx_next = 7'd0;
        end else if (ec_cur > 8'd4 && (ec_cur == 8'd5 || s_logit > best_reg)) begin
            best_next = s_logit;
            bidx_next = 7'(ec_cur - 8'd5);
        end
    end

    assign push = acc && end_cell;
    assign rec  = {box_reg[0], box_reg[1], box_reg[2], box_reg[3], obj_reg,
                   best_next, bidx_next, col_cur, row_cur, anc_cur};

    always_ff @(posedge aclk) begin
        if (acc && ec_cur < 8'd4) box_reg[ec_cur[1:0]] <= s_logit;
        if (acc && ec_cur == 8'd4) obj_reg <= s_logit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ec_reg   <= 8'd0;
            col_reg  <= '0;
            row_reg  <= '0;
            anc_reg  <= '0;
            best_reg <= -16'sd32768;
            bidx_reg <= 7'd0;
        end else if (acc) begin
            best_reg <= best_next;
            bidx_reg <= bidx_next;
            if (end_cell) begin
                ec_reg  <= 8'd0;
                col_reg <= col_cur;
                row_reg <= row_cur;
                anc_reg <= anc_cur;
                if (14'(col_cur) + 14'd1 >= wside) begin
                    col_reg <= '0;
                    if (14'(row_cur) + 14'd1 >= hside) begin
                        row_reg <= '0;
                        anc_reg <= (32'(anc_cur) + 1 >= ANCHORS_PER_CELL) ? '0 :
                                   AW'(anc_cur + 1'b1);
                    end else begin
                        row_reg <= row_cur + 1'b1;
                    end
                end else begin
                    col_reg <= col_cur + 1'b1;
                end
            end else begin
                ec_reg  <= ec_cur + 8'd1;
                col_reg <= col_cur;
                row_reg <= row_cur;
                anc_reg <= anc_cur;
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/ygbd_back.sv
// Back end: sigmoid table lookups, score threshold and box edge decode.
`default_nettype none
module ygbd_back
    import ygbd_pkg::*;
#(
    parameter int SIGMOID_TABLE_DEPTH = DEF_SIG_DEPTH,
    parameter int GW                  = 10,
    parameter int AW                  = 2,
    parameter int REC_W               = 4 * 16 + 16 + 16 + 7 + 2 * GW + AW
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire cfg_t             cfg,
    input  wire logic [REC_W-1:0] rec,
    input  wire logic             empty,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [15:0]      m_box_left,
    output logic      [15:0]      m_box_top,
    output logic      [15:0]      m_box_right,
    output logic      [15:0]      m_box_bottom,
    output logic      [6:0]       m_top_class,
    output logic      [15:0]      m_score
);
    localparam int DW = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_LOOK, ST_MUL, ST_SCALE, ST_EDGE, ST_FIN, ST_OUT
    } state_t;

    logic [15:0] rom [SIGMOID_TABLE_DEPTH];
    for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [15:0] V = sig_entry(g, SIGMOID_TABLE_DEPTH);
        assign rom[g] = V;
    end

    state_t          state_reg;
    logic [2:0]      step_reg;
    logic [REC_W-1:0] rec_reg;
    logic [15:0]     rom_q_reg;
    logic [15:0]     slot_reg [6];
    logic [31:0]     prod_reg, sw2_reg, sh2_reg;
    logic [15:0]     score_reg;
    logic signed [63:0] hw_reg, hh_reg, cx_reg, cy_reg;
    logic signed [63:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic            pass_reg;

    logic [15:0]     r_box [4];
    logic [15:0]     r_obj;
    logic [15:0]     r_best;
    logic [6:0]      r_idx;
    logic [GW-1:0]   r_col, r_row;
    logic [AW-1:0]   r_anc;
    logic [15:0]     raw_sel;
    logic [32:0]     idx_prod;
    logic [16:0]     idx_wide;
    logic [DW-1:0]   rom_addr;
    logic [31:0]     areg;
    logic signed [63:0] cxv, cyv, xmax, ymax, x1s, y1s;

    assign {r_box[0], r_box[1], r_box[2], r_box[3], r_obj, r_best, r_idx, r_col, r_row, r_anc}
        = rec_reg;

    always_comb begin
        case (step_reg)
            3'd0:    raw_sel = r_obj;
            3'd1:    raw_sel = r_best;
            3'd2:    raw_sel = r_box[0];
            3'd3:    raw_sel = r_box[1];
            3'd4:    raw_sel = r_box[2];
            3'd5:    raw_sel = r_box[3];
            default: raw_sel = r_obj;
        endcase
    end

    assign idx_prod = 33'({~raw_sel[15], raw_sel[14:0]}) * 33'(SIGMOID_TABLE_DEPTH);
    assign idx_wide = idx_prod[32:16];
    assign rom_addr = (32'(idx_wide) >= SIGMOID_TABLE_DEPTH) ?
                      DW'(SIGMOID_TABLE_DEPTH - 1) : idx_wide[DW-1:0];

    assign areg = (r_anc == AW'(0)) ? cfg.anchor_zero :
                  (r_anc == AW'(1)) ? cfg.anchor_one : cfg.anchor_two;
    assign cxv  = $signed(64'({slot_reg[2], 1'b0})) - 64'sd32768 + $signed(64'(r_col) << 16);
    assign cyv  = $signed(64'({slot_reg[3], 1'b0})) - 64'sd32768 + $signed(64'(r_row) << 16);
    assign xmax = $signed(64'(cfg.model_width) << 32);
    assign ymax = $signed(64'(cfg.model_height) << 32);
    assign x1s  = cx_reg + hw_reg;
    assign y1s  = cy_reg + hh_reg;

    assign pop = (state_reg == ST_IDLE) && !empty;

    always_ff @(posedge aclk) begin
        rom_q_reg <= rom[rom_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            m_valid   <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!empty) begin
                        rec_reg   <= rec;
                        step_reg  <= 3'd0;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    if (step_reg != 3'd0) slot_reg[step_reg - 3'd1] <= rom_q_reg;
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd6) state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= 32'(slot_reg[0]) * 32'(slot_reg[1]);
                    sw2_reg   <= 32'(slot_reg[4]) * 32'(slot_reg[4]);
                    sh2_reg   <= 32'(slot_reg[5]) * 32'(slot_reg[5]);
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    score_reg <= 16'((33'(prod_reg) + 33'd32768) >> 16);
                    hw_reg    <= $signed(64'(49'({sw2_reg, 1'b0}) * 49'(areg[31:16])));
                    hh_reg    <= $signed(64'(49'({sh2_reg, 1'b0}) * 49'(areg[15:0])));
                    cx_reg    <= cxv <<< (6'(cfg.stride_shift) + 6'd16);
                    cy_reg    <= cyv <<< (6'(cfg.stride_shift) + 6'd16);
                    state_reg <= ST_EDGE;
                end
                ST_EDGE: begin
                    pass_reg  <= (slot_reg[0] >= cfg.min_score) &&
                                 (score_reg >= cfg.min_score);
                    x0_reg    <= cx_reg - hw_reg;
                    y0_reg    <= cy_reg - hh_reg;
                    x1_reg    <= (x1s > xmax) ? xmax : x1s;
                    y1_reg    <= (y1s > ymax) ? ymax : y1s;
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (pass_reg) begin
                        m_box_left    <= to_q4(x0_reg);
                        m_box_top     <= to_q4(y0_reg);
                        m_box_right   <= to_q4(x1_reg);
                        m_box_bottom  <= to_q4(y1_reg);
                        m_top_class   <= r_idx;
                        m_score       <= score_reg;
                        m_valid       <= 1'b1;
                        state_reg     <= ST_OUT;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
